@@ hdl/scht_pkg.sv @@
// shared constants, field widths and payload structs for the segment / circle hit test
// no dependencies; used by every module in hdl/

package scht_pkg;

   // field widths
   localparam int COORD_WIDTH   = 24;
   localparam int FRACTION_BITS = 16;
   localparam int RADIUS_WIDTH  = 20;

   // derived arithmetic widths
   localparam int DIFF_W = COORD_WIDTH + 1;               // coordinate difference, signed
   localparam int PROD_W = 2 * DIFF_W;                    // signed product and dot product
   localparam int LEN_W  = 2 * COORD_WIDTH + 1;           // squared length, unsigned
   localparam int RR_W   = 2 * RADIUS_WIDTH;              // squared radius
   localparam int T_W    = FRACTION_BITS + 1;             // fraction, 0 .. one inclusive
   localparam int PX_W   = DIFF_W + T_W + 1;              // dx * t, signed
   localparam int SUM_W  = PX_W + 1;                      // scaled closest point offset
   localparam int MAG_W  = COORD_WIDTH + FRACTION_BITS;   // magnitude of that offset
   localparam int LO_W   = MAG_W / 2;
   localparam int HI_W   = MAG_W - LO_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int D2_W   = SQ_W + 1;
   localparam int LIM_W  = RR_W + 2 * FRACTION_BITS;
   localparam int CMP_W  = (D2_W > LIM_W) ? D2_W : LIM_W;

   localparam logic [T_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   // stream packing
   localparam int REQ_W       = 6 * COORD_WIDTH + RADIUS_WIDTH;
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W       = 1 + T_W;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic        [RADIUS_WIDTH-1:0] radius;
   } req_type;

   // item in flight between the front end, the divider and the distance test
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] wx;    // start - center
      logic signed [DIFF_W-1:0] wy;
      logic        [RR_W-1:0]   rr;
      logic        [LEN_W-1:0]  len2;
      logic        [LEN_W-1:0]  rem;
      logic        [T_W-1:0]    t;
      logic                     divide;
   } work_type;

endpackage

@@ hdl/scht_front.sv @@
// front end: differences, products, squared length and dot product, fraction classing
// depends on scht_pkg

module scht_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  scht_pkg::req_type  in_req,
   output logic               out_valid,
   input  logic               out_ready,
   output scht_pkg::work_type out_work
);

   localparam int NSTAGE = 4;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] go;
   logic [NSTAGE-1:0] v_prev;

   // stage 0: differences
   logic signed [scht_pkg::DIFF_W-1:0] s0_dx_ff, s0_dy_ff, s0_qx_ff, s0_qy_ff;
   logic signed [scht_pkg::DIFF_W-1:0] s0_wx_ff, s0_wy_ff;
   logic        [scht_pkg::RADIUS_WIDTH-1:0] s0_r_ff;
   // stage 1: products
   logic signed [scht_pkg::PROD_W-1:0] s1_pdx_ff, s1_pdy_ff, s1_pqx_ff, s1_pqy_ff;
   logic signed [scht_pkg::DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_wx_ff, s1_wy_ff;
   logic        [scht_pkg::RR_W-1:0]   s1_rr_ff;
   // stage 2: sums
   logic        [scht_pkg::LEN_W-1:0]  s2_len2_ff;
   logic signed [scht_pkg::PROD_W-1:0] s2_dot_ff;
   logic signed [scht_pkg::DIFF_W-1:0] s2_dx_ff, s2_dy_ff, s2_wx_ff, s2_wy_ff;
   logic        [scht_pkg::RR_W-1:0]   s2_rr_ff;
   // stage 3: classed item
   scht_pkg::work_type work_ff;
   scht_pkg::work_type work_in;

   logic signed [scht_pkg::PROD_W-1:0] len2_sum;
   logic signed [scht_pkg::PROD_W-1:0] dot_sum;
   logic                               dot_pos;

   always_comb begin
      go[NSTAGE-1] = ~v_ff[NSTAGE-1] | out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         go[k] = ~v_ff[k] | go[k+1];
      end
   end

   assign v_prev    = {v_ff[NSTAGE-2:0], in_valid};
   assign in_ready  = go[0];
   assign out_valid = v_ff[NSTAGE-1];
   assign out_work  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~go) | (v_prev & go);
      end
   end

   assign len2_sum = s1_pdx_ff + s1_pdy_ff;
   assign dot_sum  = s1_pqx_ff + s1_pqy_ff;
   assign dot_pos  = ~s2_dot_ff[scht_pkg::PROD_W-1] && (s2_dot_ff != '0);

   // zero length or center behind start gives 0, past the end gives one
   always_comb begin
      work_in.dx     = s2_dx_ff;
      work_in.dy     = s2_dy_ff;
      work_in.wx     = s2_wx_ff;
      work_in.wy     = s2_wy_ff;
      work_in.rr     = s2_rr_ff;
      work_in.len2   = s2_len2_ff;
      work_in.rem    = s2_dot_ff[scht_pkg::LEN_W-1:0];
      work_in.t      = '0;
      work_in.divide = 1'b0;
      priority if (s2_len2_ff == '0 || !dot_pos) begin
         work_in.rem = '0;
      end else if ($unsigned(s2_dot_ff) >= scht_pkg::PROD_W'(s2_len2_ff)) begin
         work_in.rem = '0;
         work_in.t   = scht_pkg::FRAC_ONE;
      end else begin
         work_in.divide = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         s0_dx_ff <= scht_pkg::DIFF_W'(in_req.end_x) - scht_pkg::DIFF_W'(in_req.start_x);
         s0_dy_ff <= scht_pkg::DIFF_W'(in_req.end_y) - scht_pkg::DIFF_W'(in_req.start_y);
         s0_qx_ff <= scht_pkg::DIFF_W'(in_req.center_x) - scht_pkg::DIFF_W'(in_req.start_x);
         s0_qy_ff <= scht_pkg::DIFF_W'(in_req.center_y) - scht_pkg::DIFF_W'(in_req.start_y);
         s0_wx_ff <= scht_pkg::DIFF_W'(in_req.start_x) - scht_pkg::DIFF_W'(in_req.center_x);
         s0_wy_ff <= scht_pkg::DIFF_W'(in_req.start_y) - scht_pkg::DIFF_W'(in_req.center_y);
         s0_r_ff  <= in_req.radius;
      end
      if (go[1]) begin
         s1_pdx_ff <= s0_dx_ff * s0_dx_ff;
         s1_pdy_ff <= s0_dy_ff * s0_dy_ff;
         s1_pqx_ff <= s0_qx_ff * s0_dx_ff;
         s1_pqy_ff <= s0_qy_ff * s0_dy_ff;
         s1_rr_ff  <= s0_r_ff * s0_r_ff;
         s1_dx_ff  <= s0_dx_ff;
         s1_dy_ff  <= s0_dy_ff;
         s1_wx_ff  <= s0_wx_ff;
         s1_wy_ff  <= s0_wy_ff;
      end
      if (go[2]) begin
         s2_len2_ff <= len2_sum[scht_pkg::LEN_W-1:0];
         s2_dot_ff  <= dot_sum;
         s2_rr_ff   <= s1_rr_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_wx_ff   <= s1_wx_ff;
         s2_wy_ff   <= s1_wy_ff;
      end
      if (go[3]) begin
         work_ff <= work_in;
      end
   end

endmodule

@@ hdl/scht_div.sv @@
// pipelined restoring divider: one quotient bit of dot / len2 per stage
// depends on scht_pkg

module scht_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  scht_pkg::work_type in_work,
   output logic               out_valid,
   input  logic               out_ready,
   output scht_pkg::work_type out_work
);

   localparam int NSTAGE = scht_pkg::FRACTION_BITS;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] go;
   logic [NSTAGE-1:0] v_prev;

   scht_pkg::work_type work_ff  [NSTAGE];
   scht_pkg::work_type stage_in [NSTAGE];

   function automatic scht_pkg::work_type div_step(scht_pkg::work_type w);
      logic [scht_pkg::LEN_W:0] rem2;
      logic                     ge;
      scht_pkg::work_type       r;
      r    = w;
      rem2 = {w.rem, 1'b0};
      ge   = rem2 >= {1'b0, w.len2};
      if (w.divide) begin
         r.t   = {w.t[scht_pkg::T_W-2:0], ge};
         r.rem = ge ? scht_pkg::LEN_W'(rem2 - {1'b0, w.len2}) : rem2[scht_pkg::LEN_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      go[NSTAGE-1] = ~v_ff[NSTAGE-1] | out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         go[k] = ~v_ff[k] | go[k+1];
      end
   end

   always_comb begin
      stage_in[0] = in_work;
      for (int k = 1; k < NSTAGE; k++) begin
         stage_in[k] = work_ff[k-1];
      end
   end

   assign v_prev    = {v_ff[NSTAGE-2:0], in_valid};
   assign in_ready  = go[0];
   assign out_valid = v_ff[NSTAGE-1];
   assign out_work  = work_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~go) | (v_prev & go);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (go[k]) begin
            work_ff[k] <= div_step(stage_in[k]);
         end
      end
   end

endmodule

@@ hdl/scht_dist.sv @@
// closest point, squared distance and inclusive radius test, with the output register
// depends on scht_pkg

module scht_dist (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  scht_pkg::work_type           in_work,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         out_hit,
   output logic [scht_pkg::T_W-1:0]     out_frac
);

   localparam int NSTAGE = 7;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] go;
   logic [NSTAGE-1:0] v_prev;

   // fraction and squared radius ride along stages 0 to 5, up to the output register
   logic [scht_pkg::T_W-1:0]  t_ff  [NSTAGE-1];
   logic [scht_pkg::RR_W-1:0] rr_ff [NSTAGE-1];

   // stage 0: dx * t
   logic signed [scht_pkg::PX_W-1:0]   s0_px_ff, s0_py_ff;
   logic signed [scht_pkg::DIFF_W-1:0] s0_wx_ff, s0_wy_ff;
   // stage 1: offset from center, scaled by one
   logic signed [scht_pkg::SUM_W-1:0]  s1_ex_ff, s1_ey_ff;
   // stage 2: magnitude halves
   logic [scht_pkg::HI_W-1:0] s2_hx_ff, s2_hy_ff;
   logic [scht_pkg::LO_W-1:0] s2_lx_ff, s2_ly_ff;
   // stage 3: partial products
   logic [2*scht_pkg::HI_W-1:0]           s3_hhx_ff, s3_hhy_ff;
   logic [scht_pkg::HI_W+scht_pkg::LO_W-1:0] s3_hlx_ff, s3_hly_ff;
   logic [2*scht_pkg::LO_W-1:0]           s3_llx_ff, s3_lly_ff;
   // stage 4 and 5: squares and their sum
   logic [scht_pkg::SQ_W-1:0] s4_sqx_ff, s4_sqy_ff;
   logic [scht_pkg::D2_W-1:0] s5_d2_ff;
   // stage 6: output register
   logic                      hit_ff;
   logic [scht_pkg::T_W-1:0]  frac_ff;

   logic signed [scht_pkg::SUM_W-1:0] ax_abs, ay_abs;
   logic [scht_pkg::MAG_W-1:0]        mx, my;
   logic [scht_pkg::CMP_W-1:0]        lim;
   logic                              hit_in;

   always_comb begin
      go[NSTAGE-1] = ~v_ff[NSTAGE-1] | out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         go[k] = ~v_ff[k] | go[k+1];
      end
   end

   assign v_prev    = {v_ff[NSTAGE-2:0], in_valid};
   assign in_ready  = go[0];
   assign out_valid = v_ff[NSTAGE-1];
   assign out_hit   = hit_ff;
   assign out_frac  = frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~go) | (v_prev & go);
      end
   end

   assign ax_abs = s1_ex_ff[scht_pkg::SUM_W-1] ? -s1_ex_ff : s1_ex_ff;
   assign ay_abs = s1_ey_ff[scht_pkg::SUM_W-1] ? -s1_ey_ff : s1_ey_ff;
   assign mx     = ax_abs[scht_pkg::MAG_W-1:0];
   assign my     = ay_abs[scht_pkg::MAG_W-1:0];

   assign lim    = scht_pkg::CMP_W'(rr_ff[NSTAGE-2]) << (2 * scht_pkg::FRACTION_BITS);
   assign hit_in = scht_pkg::CMP_W'(s5_d2_ff) <= lim;

   always_ff @(posedge clock) begin
      if (go[0]) begin
         s0_px_ff <= in_work.dx * $signed({1'b0, in_work.t});
         s0_py_ff <= in_work.dy * $signed({1'b0, in_work.t});
         s0_wx_ff <= in_work.wx;
         s0_wy_ff <= in_work.wy;
         t_ff[0]  <= in_work.t;
         rr_ff[0] <= in_work.rr;
      end
      for (int k = 1; k < NSTAGE - 1; k++) begin
         if (go[k]) begin
            t_ff[k]  <= t_ff[k-1];
            rr_ff[k] <= rr_ff[k-1];
         end
      end
      if (go[1]) begin
         s1_ex_ff <= (scht_pkg::SUM_W'(s0_wx_ff) <<< scht_pkg::FRACTION_BITS)
                     + scht_pkg::SUM_W'(s0_px_ff);
         s1_ey_ff <= (scht_pkg::SUM_W'(s0_wy_ff) <<< scht_pkg::FRACTION_BITS)
                     + scht_pkg::SUM_W'(s0_py_ff);
      end
      if (go[2]) begin
         s2_hx_ff <= mx[scht_pkg::MAG_W-1:scht_pkg::LO_W];
         s2_lx_ff <= mx[scht_pkg::LO_W-1:0];
         s2_hy_ff <= my[scht_pkg::MAG_W-1:scht_pkg::LO_W];
         s2_ly_ff <= my[scht_pkg::LO_W-1:0];
      end
      if (go[3]) begin
         s3_hhx_ff <= s2_hx_ff * s2_hx_ff;
         s3_hlx_ff <= s2_hx_ff * s2_lx_ff;
         s3_llx_ff <= s2_lx_ff * s2_lx_ff;
         s3_hhy_ff <= s2_hy_ff * s2_hy_ff;
         s3_hly_ff <= s2_hy_ff * s2_ly_ff;
         s3_lly_ff <= s2_ly_ff * s2_ly_ff;
      end
      if (go[4]) begin
         s4_sqx_ff <= (scht_pkg::SQ_W'(s3_hhx_ff) << (2 * scht_pkg::LO_W))
                      + (scht_pkg::SQ_W'(s3_hlx_ff) << (scht_pkg::LO_W + 1))
                      + scht_pkg::SQ_W'(s3_llx_ff);
         s4_sqy_ff <= (scht_pkg::SQ_W'(s3_hhy_ff) << (2 * scht_pkg::LO_W))
                      + (scht_pkg::SQ_W'(s3_hly_ff) << (scht_pkg::LO_W + 1))
                      + scht_pkg::SQ_W'(s3_lly_ff);
      end
      if (go[5]) begin
         s5_d2_ff <= scht_pkg::D2_W'(s4_sqx_ff) + scht_pkg::D2_W'(s4_sqy_ff);
      end
      if (go[6]) begin
         hit_ff  <= hit_in;
         frac_ff <= hit_in ? t_ff[NSTAGE-2] : '0;
      end
   end

endmodule

@@ hdl/segment_circle_hit_test.sv @@
// pipeline: 4 front, 16 divider and 7 distance stages from request to response
// throughput: one request per cycle; a stalled response holds only the stages behind it,
// empty stages keep filling so requests are still taken while a response waits
// reset: synchronous, active high; clears every stage valid bit, payload is not reset
// top level of the segment / circle hit test; depends on scht_pkg, scht_front,
// scht_div and scht_dist

module segment_circle_hit_test (
   input  logic                               clock,
   input  logic                               reset,
   // request: start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [scht_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // response: hit, hit_fraction, zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [scht_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CW = scht_pkg::COORD_WIDTH;

   scht_pkg::req_type  req;
   scht_pkg::work_type front_work;
   scht_pkg::work_type div_work;

   logic front_valid, front_ready;
   logic div_valid, div_ready;
   logic hit;
   logic [scht_pkg::T_W-1:0] hit_fraction;

   // unpack request fields, lowest field first
   assign req.start_x  = req_tdata[1*CW-1:0*CW];
   assign req.start_y  = req_tdata[2*CW-1:1*CW];
   assign req.end_x    = req_tdata[3*CW-1:2*CW];
   assign req.end_y    = req_tdata[4*CW-1:3*CW];
   assign req.center_x = req_tdata[5*CW-1:4*CW];
   assign req.center_y = req_tdata[6*CW-1:5*CW];
   assign req.radius   = req_tdata[6*CW+scht_pkg::RADIUS_WIDTH-1:6*CW];

   // squared length, dot product and the clamped cases
   scht_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_work  (front_work)
   );

   // fraction = dot / len2 in q1.16, rounded down, one bit per stage
   scht_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_work   (front_work),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_work  (div_work)
   );

   // exact closest point distance against radius, inclusive; fraction zeroed on a miss
   scht_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_work   (div_work),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit),
      .out_frac  (hit_fraction)
   );

   assign rsp_tdata = scht_pkg::RSP_TDATA_W'({hit_fraction, hit});

endmodule
